### hw/rtl/itew_pkg.sv
package itew_pkg;

  localparam int VALUE_W = 31;
  localparam int WORD_W = 5;
  localparam int DIGITS = 10;
  localparam int BCD_W = 4 * DIGITS;
  localparam int CNT_W = $clog2(VALUE_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0] digit_t;

  localparam word_t W_ZERO = 5'd0;
  localparam word_t W_TEN = 5'd10;
  localparam word_t W_TENS_BASE = 5'd18;
  localparam word_t W_HUNDRED = 5'd28;
  localparam word_t W_THOUSAND = 5'd29;
  localparam word_t W_MILLION = 5'd30;
  localparam word_t W_BILLION = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_GEN,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    STEP_HUND_DIGIT,
    STEP_HUND_WORD,
    STEP_TENS,
    STEP_ONES,
    STEP_PLACE
  } step_t;

  typedef enum logic [1:0] {
    GRP_BILLION,
    GRP_MILLION,
    GRP_THOUSAND,
    GRP_UNIT
  } grp_t;

endpackage

### hw/rtl/itew_in_if.sv
interface itew_in_if;
  import itew_pkg::*;

  logic valid;
  logic ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### hw/rtl/itew_out_if.sv
interface itew_out_if;
  import itew_pkg::*;

  logic valid;
  logic ready;
  logic [WORD_W-1:0] word;
  logic last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink (input valid, input word, input last_word, output ready);
endinterface

### hw/rtl/integer_to_english_words_top.sv
// Sequence: an accept in idle, bit-serial binary-to-decimal shifting of all 31 bits, then
// 19 word-sequencing steps (one per cycle while the output is not stalled) and one flush.
// An output stall during sequencing or flush holds the sequencer in its current step.
// Only one item is in flight: a new value is accepted only in idle, after the flush,
// so the 31-bit shift conversion and the sequencer set the throughput.
// Reset (rst, synchronous, active high) returns to idle with no result pending.
module integer_to_english_words_top (
  input  logic       clk,
  input  logic       rst,
  itew_in_if.sink    item_in,
  itew_out_if.source word_out
);
  import itew_pkg::*;

  state_t state, state_next;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt;
  grp_t grp;
  step_t step;
  logic pend_valid;
  word_t pend_word;
  logic out_valid;
  word_t out_word;
  logic out_last;

  logic slot_free;
  logic load_out;
  digit_t dh, dt, d_o;
  logic grp_nz;
  logic emit;
  word_t emit_word;
  word_t place_word;

  assign slot_free = !out_valid || word_out.ready;
  assign load_out = slot_free && ((state == ST_GEN && emit && pend_valid) || state == ST_FLUSH);
  assign word_out.valid = out_valid;
  assign word_out.word = out_word;
  assign word_out.last_word = out_last;

  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    case (grp)
      GRP_BILLION: begin
        dh = '0; dt = '0; d_o = bcd[39:36]; place_word = W_BILLION;
      end
      GRP_MILLION: begin
        dh = bcd[35:32]; dt = bcd[31:28]; d_o = bcd[27:24]; place_word = W_MILLION;
      end
      GRP_THOUSAND: begin
        dh = bcd[23:20]; dt = bcd[19:16]; d_o = bcd[15:12]; place_word = W_THOUSAND;
      end
      default: begin
        dh = bcd[11:8]; dt = bcd[7:4]; d_o = bcd[3:0]; place_word = W_ZERO;
      end
    endcase
  end

  assign grp_nz = (dh != '0) || (dt != '0) || (d_o != '0);

  always_comb begin
    item_in.ready = (state == ST_IDLE);
    emit = 1'b0;
    emit_word = W_ZERO;
    case (step)
      STEP_HUND_DIGIT: begin
        emit = (dh != '0);
        emit_word = {1'b0, dh};
      end
      STEP_HUND_WORD: begin
        emit = (dh != '0);
        emit_word = W_HUNDRED;
      end
      STEP_TENS: begin
        if (dt >= 4'd2) begin
          emit = 1'b1;
          emit_word = W_TENS_BASE + {1'b0, dt};
        end else if (dt == 4'd1) begin
          emit = 1'b1;
          emit_word = W_TEN + {1'b0, d_o};
        end else begin
          emit = (d_o != '0);
          emit_word = {1'b0, d_o};
        end
      end
      STEP_ONES: begin
        emit = (dt >= 4'd2) && (d_o != '0);
        emit_word = {1'b0, d_o};
      end
      STEP_PLACE: begin
        emit = grp_nz && (grp != GRP_UNIT);
        emit_word = place_word;
      end
      default: begin
        emit = 1'b0;
        emit_word = W_ZERO;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_in.valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (cnt == CNT_W'(VALUE_W - 1)) state_next = ST_GEN;
      end
      ST_GEN: begin
        if (slot_free && grp == GRP_UNIT && step == STEP_ONES) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
      cnt <= '0;
      grp <= GRP_BILLION;
      step <= STEP_HUND_DIGIT;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (word_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_in.valid) begin
            bin <= item_in.value;
            bcd <= '0;
            cnt <= '0;
          end
        end
        ST_CONV: begin
          bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          grp <= GRP_BILLION;
          step <= STEP_HUND_DIGIT;
          pend_valid <= 1'b0;
        end
        ST_GEN: begin
          if (slot_free) begin
            if (emit) begin
              pend_valid <= 1'b1;
              pend_word <= emit_word;
              if (pend_valid) begin
                out_word <= pend_word;
                out_last <= 1'b0;
              end
            end
            if (step == STEP_PLACE || (grp == GRP_UNIT && step == STEP_ONES)) begin
              step <= STEP_HUND_DIGIT;
              grp <= grp_t'(grp + 2'd1);
            end else begin
              step <= step_t'(step + 3'd1);
            end
          end
        end
        ST_FLUSH: begin
          if (slot_free) begin
            out_word <= pend_valid ? pend_word : W_ZERO;
            out_last <= 1'b1;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          pend_valid <= 1'b0;
        end
      endcase
    end
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready |=> state == ST_CONV && cnt == '0)
    else $error("accepted item did not start conversion");

  a_bcd_digits_legal: assert property (@(posedge clk) disable iff (rst)
    state == ST_GEN |-> bcd[39:36] <= 4'd9 && bcd[35:32] <= 4'd9 && bcd[31:28] <= 4'd9
      && bcd[27:24] <= 4'd9 && bcd[23:20] <= 4'd9 && bcd[19:16] <= 4'd9
      && bcd[15:12] <= 4'd9 && bcd[11:8] <= 4'd9 && bcd[7:4] <= 4'd9 && bcd[3:0] <= 4'd9)
    else $error("decimal digit out of range after conversion");

  a_word_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_GEN || $past(state) == ST_FLUSH)
    else $error("word issued outside sequencing");

  a_flush_ends_item: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH && slot_free |=> state == ST_IDLE && out_valid && out_last)
    else $error("flush did not issue the final word");

endmodule
